>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules of the palette index remap block
// expects a clock named clk and an active-low reset named rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next edge
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

>>> hw/rtl/bmpr_pkg.sv
// shared types and codes for the bitmap palette index remap block
// no dependencies
package bmpr_pkg;

  localparam int TABLE_WIDTH = 8;
  localparam int TABLE_DEPTH = 256;

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // request kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // pixel formats
  localparam logic [1:0] FMT_RAW8 = 2'd0;
  localparam logic [1:0] FMT_RAW4 = 2'd1;
  localparam logic [1:0] FMT_RLE8 = 2'd2;

  // rle8 parser phases
  localparam logic [2:0] PH_COUNT  = 3'd0;
  localparam logic [2:0] PH_RUNVAL = 3'd1;
  localparam logic [2:0] PH_ESCAPE = 3'd2;
  localparam logic [2:0] PH_DX     = 3'd3;
  localparam logic [2:0] PH_DY     = 3'd4;
  localparam logic [2:0] PH_ABS    = 3'd5;
  localparam logic [2:0] PH_PAD    = 3'd6;

  // rle8 escape codes
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic xlat;        // current byte is a pixel value
    logic done_after;  // end-of-bitmap flag after this byte
  } parse_t;

endpackage

>>> hw/rtl/bmpr_ram.sv
// generic single-write, single-read ram with registered read data
// depends on bmpr_pkg for default sizes
module bmpr_ram
  import bmpr_pkg::*;
#(
  parameter int WIDTH = TABLE_WIDTH,
  parameter int DEPTH = TABLE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bmpr_parse.sv
// rle8 stream parser: tracks phase, run length, pad and end-of-bitmap
// depends on bmpr_pkg and assert_macros.svh
`include "assert_macros.svh"

module bmpr_parse
  import bmpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,       // rle8 pixel byte accepted this cycle
  input  logic       restart,
  input  logic [7:0] data_byte,
  output parse_t     parse
);

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] run_r, run_nxt;
  logic       pad_r, pad_nxt;
  logic       done_r, done_nxt;
  logic [7:0] run_dec;
  logic       xlat;

  assign run_dec = run_r - 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    pad_nxt   = pad_r;
    done_nxt  = done_r;
    xlat      = 1'b0;
    if (!done_r) begin
      unique case (phase_r)
        PH_COUNT: begin
          if (data_byte == 8'd0) begin
            phase_nxt = PH_ESCAPE;
          end else begin
            run_nxt   = data_byte;
            phase_nxt = PH_RUNVAL;
          end
        end
        PH_RUNVAL: begin
          xlat      = 1'b1;
          phase_nxt = PH_COUNT;
        end
        PH_ESCAPE: begin
          case (data_byte)
            ESC_EOL: phase_nxt = PH_COUNT;
            ESC_EOB: begin
              done_nxt  = 1'b1;
              phase_nxt = PH_COUNT;
            end
            ESC_DELTA: phase_nxt = PH_DX;
            default: begin
              // absolute run, odd length is followed by a pad byte
              run_nxt   = data_byte;
              pad_nxt   = data_byte[0];
              phase_nxt = PH_ABS;
            end
          endcase
        end
        PH_DX: phase_nxt = PH_DY;
        PH_DY: phase_nxt = PH_COUNT;
        PH_ABS: begin
          xlat    = 1'b1;
          run_nxt = run_dec;
          if (run_dec == 8'd0) begin
            phase_nxt = pad_r ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_COUNT;
        end
        default: phase_nxt = PH_COUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r <= PH_COUNT;
      run_r   <= 8'd0;
      pad_r   <= 1'b0;
      done_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      pad_r   <= pad_nxt;
      done_r  <= done_nxt;
    end
  end

  assign parse.xlat       = xlat;
  assign parse.done_after = step ? done_nxt : done_r;

  `ASSERT_NEXT(a_done_sticky, done_r && !restart, done_r, "end-of-bitmap cleared without restart")
  `ASSERT_CLK(a_abs_run_live, (phase_r != PH_ABS) || (run_r != 8'd0), "absolute run with zero count")

endmodule

>>> hw/rtl/bitmap_palette_index_remap.sv
// top level of the bitmap palette index remap block
// depends on bmpr_pkg, bmpr_ram, bmpr_parse and assert_macros.svh
//
// Takes one request per clock, unless the input stalls, and returns one
// result per pixel byte. The result of a byte passes through the registered
// read of the translation table ram, then through the output register.
// Table writes and restarts give no result; a table entry written by one
// request is seen by the very next pixel byte. The table is held twice, in
// two 256x8 rams written together, so that 4-bit mode reads both nibbles
// of a byte in the same cycle. Input stalls only when the ram stage holds a
// result and the output register holds one that out_stall holds back.
`include "assert_macros.svh"

module bitmap_palette_index_remap
  import bmpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_table_index,
  input  logic [7:0] in_table_value,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_end_seen
);

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_X8   = 2'd1;
  localparam logic [1:0] MODE_X4   = 2'd2;

  logic [1:0] fmt_r;
  logic       in_acc, pix_acc, wr_acc, rst_acc;
  logic       out_ready;
  parse_t     parse;
  logic [1:0] mode;
  logic [7:0] addr_lo, addr_hi;
  logic [7:0] rd_lo, rd_hi;

  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic [7:0] s1_result;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RAW8;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;
  assign pix_acc   = in_acc && (in_kind == KIND_PIXEL);
  assign wr_acc    = in_acc && (in_kind == KIND_WRITE);
  assign rst_acc   = in_acc && (in_kind == KIND_RESTART);

  bmpr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (pix_acc && (fmt_r == FMT_RLE8)),
    .restart   (rst_acc),
    .data_byte (in_data_byte),
    .parse     (parse)
  );

  always_comb begin
    unique case (fmt_r)
      FMT_RAW8: mode = MODE_X8;
      FMT_RAW4: mode = MODE_X4;
      FMT_RLE8: mode = parse.xlat ? MODE_X8 : MODE_PASS;
      default:  mode = MODE_PASS;
    endcase
  end

  assign addr_lo = (fmt_r == FMT_RAW4) ? (in_data_byte & NIBBLE_MASK) : in_data_byte;
  assign addr_hi = {4'd0, in_data_byte[7:4]};

  bmpr_ram #(.WIDTH(TABLE_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (in_table_index),
    .wdata (in_table_value),
    .re    (pix_acc),
    .raddr (addr_lo),
    .rdata (rd_lo)
  );

  bmpr_ram #(.WIDTH(TABLE_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (in_table_index),
    .wdata (in_table_value),
    .re    (pix_acc),
    .raddr (addr_hi),
    .rdata (rd_hi)
  );

  // ram stage
  assign s1_valid_nxt = pix_acc ? 1'b1 : (s1_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_mode_r <= mode;
      s1_byte_r <= in_data_byte;
      s1_end_r  <= parse.done_after;
    end
  end

  always_comb begin
    case (s1_mode_r)
      MODE_X8: s1_result = rd_lo;
      MODE_X4: s1_result = rd_lo | {rd_hi[3:0], 4'd0};
      default: s1_result = s1_byte_r;
    endcase
  end

  // output register
  assign out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_byte_r <= s1_result;
      out_end_r  <= s1_end_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_end_seen = out_end_r;

  `ASSERT_NEXT(a_ram_hold, s1_valid_r && !out_ready, s1_valid_r && $stable(rd_lo) && $stable(rd_hi), "table read data lost while ram stage stalled")
  `ASSERT_CLK(a_no_pix_when_full, !(pix_acc && s1_valid_r && !out_ready), "pixel accepted into a held ram stage")

endmodule

>>> tb/tb.sv
// testbench for bitmap_palette_index_remap: tracks the translation table and the
// rle8 parser, and checks each result byte and end flag against the tracked state
// depends on bmpr_pkg and the block's rtl
module tb
  import bmpr_pkg::*;
();

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int LONG_HOLD       = 80;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_kind;
  logic [7:0] in_table_index;
  logic [7:0] in_table_value;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_end_seen;

  bit          no_idle;
  // count of long hold-offs asked for, the stall process keeps its own count
  int unsigned long_hold_reqs = 0;
  int unsigned quiet_cycles = 0;

  typedef struct packed {
    logic [7:0] pix;
    logic       done;
  } remap_result_t;

  // shadow of the table and the rle8 parser, with the results still owed
  class remap_tracker;
    logic [7:0]    remap[256];
    bit            written[256];
    logic [7:0]    written_list[$];
    logic [2:0]    phase;
    logic [7:0]    run_left;
    bit            pad_due;
    bit            done;
    logic [1:0]    fmt;
    remap_result_t expected_results[$];
    int            errors;

    function new();
      phase    = PH_COUNT;
      run_left = 8'd0;
      pad_due  = 1'b0;
      done     = 1'b0;
      fmt      = FMT_RAW8;
      errors   = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function logic [7:0] rle_step(logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (done) return b;
      case (phase)
        PH_COUNT: begin
          if (b == 8'd0) phase = PH_ESCAPE;
          else begin
            run_left = b;
            phase = PH_RUNVAL;
          end
        end
        PH_RUNVAL: begin
          r = remap[b];
          phase = PH_COUNT;
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) phase = PH_COUNT;
          else if (b == ESC_EOB) begin
            done = 1'b1;
            phase = PH_COUNT;
          end else if (b == ESC_DELTA) phase = PH_DX;
          else begin
            run_left = b;
            pad_due = b[0];
            phase = PH_ABS;
          end
        end
        PH_DX: phase = PH_DY;
        PH_DY: phase = PH_COUNT;
        PH_ABS: begin
          r = remap[b];
          run_left = run_left - 8'd1;
          if (run_left == 8'd0) phase = pad_due ? PH_PAD : PH_COUNT;
        end
        PH_PAD: begin
          pad_due = 1'b0;
          phase = PH_COUNT;
        end
        default: phase = PH_COUNT;
      endcase
      return r;
    endfunction

    function logic [7:0] translate_byte(logic [7:0] b);
      logic [7:0] lo_v;
      logic [7:0] hi_v;
      case (fmt)
        FMT_RAW8: return remap[b];
        FMT_RAW4: begin
          lo_v = remap[b & NIBBLE_MASK];
          hi_v = remap[{4'h0, b[7:4]}];
          return lo_v | {hi_v[3:0], 4'h0};
        end
        FMT_RLE8: return rle_step(b);
        default:  return b;
      endcase
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] idx, logic [7:0] val,
                               logic [7:0] b);
      remap_result_t res;
      case (kind)
        KIND_WRITE: begin
          remap[idx] = val;
          if (!written[idx]) written_list.push_back(idx);
          written[idx] = 1'b1;
        end
        KIND_PIXEL: begin
          res.pix  = translate_byte(b);
          res.done = done;
          expected_results.push_back(res);
        end
        KIND_RESTART: begin
          phase    = PH_COUNT;
          run_left = 8'd0;
          pad_due  = 1'b0;
          done     = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] got_byte, logic got_end);
      remap_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("out_byte: no result expected, got %h", got_byte);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (got_byte !== exp_res.pix) begin
        $error("out_byte: expected %h, got %h", exp_res.pix, got_byte);
        errors++;
      end
      if (got_end !== exp_res.done) begin
        $error("end_seen: expected %b, got %b", exp_res.done, got_end);
        errors++;
      end
    endfunction

    // any byte whose table entry is loaded
    function logic [7:0] pick_pixel(logic [7:0] b);
      if (!written[b]) b = written_list[$urandom_range(0, written_list.size() - 1)];
      return b;
    endfunction

    // entries 0 and 15 are loaded before 4-bit mode is used
    function logic [3:0] pick_nibble();
      logic [7:0] n;
      n = 8'($urandom_range(0, 15));
      if (!written[n]) n = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'h0F;
      return n[3:0];
    endfunction
  endclass

  remap_tracker sb;

  bitmap_palette_index_remap dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_end_seen   (out_end_seen)
  );

  always #1 clk = ~clk;

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] kind, input logic [7:0] idx,
                              input logic [7:0] val, input logic [7:0] b);
    in_kind        = kind;
    in_table_index = idx;
    in_table_value = val;
    in_data_byte   = b;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(kind, idx, val, b);
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] b);
    send_request(KIND_PIXEL, 8'($urandom), 8'($urandom), b);
  endtask

  task automatic idle_gap(input int unsigned n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_format(input logic [1:0] f);
    wait_drain();
    // writes and restarts may still be in the pipeline
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = f;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.fmt = f;
  endtask

  // mostly well-formed rle8 code, driven by the tracked parser phase
  function automatic logic [7:0] pick_rle_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!sb.done && (sb.phase == PH_RUNVAL || sb.phase == PH_ABS))
      return sb.pick_pixel(8'($urandom));
    if (sb.done || roll < 8) return 8'($urandom);
    case (sb.phase)
      PH_COUNT: return (roll < 30) ? 8'h00 : 8'($urandom_range(1, 255));
      PH_ESCAPE: begin
        if (roll < 22) return ESC_EOL;
        if (roll < 28) return ESC_EOB;
        if (roll < 42) return ESC_DELTA;
        if (roll < 45) return 8'($urandom_range(3, 255));
        return 8'($urandom_range(3, 12));
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_request();
    int unsigned roll;
    logic [7:0] pick;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      pick = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      send_request(KIND_WRITE, pick, 8'($urandom), 8'($urandom));
    end else if (roll < 14 || (sb.fmt == FMT_RLE8 && sb.done && roll < 40)) begin
      send_request(KIND_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      case (sb.fmt)
        FMT_RAW8: pick = sb.pick_pixel(8'($urandom));
        FMT_RAW4: pick = {sb.pick_nibble(), sb.pick_nibble()};
        default:  pick = pick_rle_byte();
      endcase
      send_pixel(pick);
    end
  endtask

  // result side: random stall bursts, plus the long hold-off on request
  initial begin : stall_gen
    int unsigned stall_left;
    int unsigned long_hold_seen;
    stall_left     = 0;
    long_hold_seen = 0;
    out_stall      = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_reqs != long_hold_seen) begin
        stall_left     = LONG_HOLD;
        long_hold_seen = long_hold_reqs;
      end
      if (stall_left == 0 && !no_idle && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_byte, out_end_seen);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] raw8_bytes[4];
    logic [7:0] raw4_bytes[3];
    logic [7:0] rle_bytes[17];
    logic [1:0] phase_fmt[NUM_PHASES];

    raw8_bytes = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
    raw4_bytes = '{8'h0F, 8'hF0, 8'hFF};
    // long run, end-of-line, delta, odd absolute run with pad, end-of-bitmap,
    // then a byte after the end
    rle_bytes  = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00,
                   8'h00, 8'h03, 8'h00, 8'hFF, 8'h0F, 8'hAB, 8'h00, 8'h01, 8'h7E};
    phase_fmt  = '{FMT_RLE8, FMT_RAW8, FMT_RAW4, FMT_RLE8,
                   FMT_RAW8, FMT_RLE8, FMT_RAW4, FMT_RLE8};

    sb             = new();
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = FMT_RAW8;
    in_valid       = 1'b0;
    in_kind        = KIND_WRITE;
    in_table_index = 8'd0;
    in_table_value = 8'd0;
    in_data_byte   = 8'd0;
    no_idle        = 1'b0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: table extremes, each format, each rle8 code
    set_format(FMT_RAW8);
    send_request(KIND_WRITE, 8'h00, 8'hFF, 8'h00);
    send_request(KIND_WRITE, 8'hFF, 8'h00, 8'hFF);
    send_request(KIND_WRITE, 8'h0F, 8'hA5, 8'h00);
    send_request(KIND_WRITE, 8'hF0, 8'h5A, 8'hFF);
    foreach (raw8_bytes[i]) send_pixel(raw8_bytes[i]);
    set_format(FMT_RAW4);
    foreach (raw4_bytes[i]) send_pixel(raw4_bytes[i]);
    set_format(FMT_RLE8);
    foreach (rle_bytes[i]) send_pixel(rle_bytes[i]);
    send_request(KIND_RESTART, 8'h00, 8'h00, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_format(phase_fmt[p]);
      no_idle = (p == NUM_PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // receiver holds off while requests keep coming, so the block fills up
        if (p == 1 && i == 20) long_hold_reqs++;
        if (p == 2 && i == 40) wait_drain();
        if (!no_idle && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 14));
        send_random_request();
      end
    end

    wait_drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bmpr_pkg.sv
hw/rtl/bmpr_ram.sv
hw/rtl/bmpr_parse.sv
hw/rtl/bitmap_palette_index_remap.sv
tb/tb.sv
